// ===== hw/rtl/edf_pkg.sv =====
package edf_pkg;

	localparam int NTASK = 16;
	localparam int IDXW  = 4;
	localparam int QDEPTH = 2;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  task_index;
		logic [15:0] burst;
		logic [15:0] rel_deadline;
		logic [15:0] period;
	} cmd_t;

endpackage

// ===== hw/rtl/edf_periodic_task_scheduler.sv =====
// edf scheduler: a load word writes the table from the idle state; a tick word holds the
// sequencer for accept, then release pass, edf scan, phase update, one slot per cycle
// outside a stall: the update pass waits on its first slot while the previous result is
// not yet taken
// a two-word queue decouples input from the sequencer; one result register
// arst_n clears valid flags, running state, time and handshake state
module edf_periodic_task_scheduler
	import edf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // task_index, burst, rel_deadline, period
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // tick_time, task_id
	output logic        m_tuser   // busy_res
);

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	// front: unpack and queue
	edf_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.cmd_valid, .cmd_ready, .cmd
	);

	// back: table, release, scan, update
	edf_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

endmodule

// ===== hw/rtl/edf_front.sv =====
// input side: unpacks words into commands and buffers them in a short queue
module edf_front
	import edf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // task_index, burst, rel_deadline, period
	input  logic        s_tuser,  // req_type
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t       q_mem_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.req_type     = s_tuser;
		in_cmd.task_index   = s_tdata[3:0];
		in_cmd.burst        = s_tdata[19:4];
		in_cmd.rel_deadline = s_tdata[35:20];
		in_cmd.period       = s_tdata[51:36];
	end

	assign s_tready  = (cnt_q != 2'(QDEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QDEPTH) |-> !push) else $error("push into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");
`endif

endmodule

// ===== hw/rtl/edf_back.sv =====
// execution side: loads, release pass, edf scan, update pass
module edf_back
	import edf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // tick_time, task_id
	output logic        m_tuser   // busy_res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_REL  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]  state_q;
	logic [IDXW-1:0] idx_q;

	logic [NTASK-1:0] valid_q;
	logic [15:0] burst_q    [NTASK];
	logic [15:0] reldl_q    [NTASK];
	logic [15:0] period_q   [NTASK];
	logic [15:0] rem_q      [NTASK];
	logic [31:0] absdl_q    [NTASK];
	logic [15:0] phase_q    [NTASK];
	logic [31:0] time_q;

	logic        found_q;
	logic [31:0] best_q;
	logic [IDXW-1:0] pick_q;

	logic        out_valid_q;
	logic [31:0] out_time_q;
	logic        out_busy_q;
	logic [3:0]  out_id_q;

	logic last;
	logic ready_i;
	logic [16:0] nxt;
	logic [15:0] per;
	logic out_free;
	logic emit;

	assign last      = (idx_q == IDXW'(NTASK - 1));
	assign cmd_ready = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'd0, out_id_q, out_time_q};
	assign m_tuser   = out_busy_q;
	assign ready_i   = valid_q[idx_q] && (rem_q[idx_q] != 16'd0);
	assign per       = (period_q[idx_q] == 16'd0) ? 16'd1 : period_q[idx_q];
	assign nxt       = {1'b0, phase_q[idx_q]} + 17'd1;
	// result register free now or freed at this edge
	assign out_free  = !out_valid_q || m_tready;
	assign emit      = (state_q == ST_UPD) && (idx_q == '0) && out_free;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_ready && cmd.req_type == REQ_LOAD) begin
			burst_q[cmd.task_index]  <= cmd.burst;
			reldl_q[cmd.task_index]  <= cmd.rel_deadline;
			period_q[cmd.task_index] <= cmd.period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			time_q      <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			out_valid_q <= 1'b0;
			out_time_q  <= '0;
			out_busy_q  <= 1'b0;
			out_id_q    <= '0;
			for (int i = 0; i < NTASK; i++) begin
				rem_q[i]   <= '0;
				absdl_q[i] <= '0;
				phase_q[i] <= '0;
			end
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						if (cmd.req_type == REQ_LOAD) begin
							valid_q[cmd.task_index] <= 1'b1;
							rem_q[cmd.task_index]   <= '0;
							absdl_q[cmd.task_index] <= '0;
							phase_q[cmd.task_index] <= '0;
						end else begin
							idx_q   <= '0;
							state_q <= ST_REL;
						end
					end
				end
				ST_REL: begin
					if (valid_q[idx_q] && phase_q[idx_q] == 16'd0) begin
						rem_q[idx_q]   <= burst_q[idx_q];
						absdl_q[idx_q] <= time_q + {16'd0, reldl_q[idx_q]};
					end
					idx_q <= idx_q + 1'b1;
					if (last) begin
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ready_i && (!found_q || absdl_q[idx_q] < best_q)) begin
						found_q <= 1'b1;
						best_q  <= absdl_q[idx_q];
						pick_q  <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
					if (last) state_q <= ST_UPD;
				end
				ST_UPD: begin
					// first slot waits while the previous result is still held
					if (idx_q != '0 || out_free) begin
						if (idx_q == '0) begin
							out_time_q <= time_q;
							out_busy_q <= found_q;
							out_id_q   <= found_q ? pick_q : '0;
							if (found_q) rem_q[pick_q] <= rem_q[pick_q] - 16'd1;
						end
						if (valid_q[idx_q])
							phase_q[idx_q] <= (nxt >= {1'b0, per}) ? 16'd0 : nxt[15:0];
						idx_q <= idx_q + 1'b1;
						if (last) begin
							time_q  <= time_q + 32'd1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q) else $error("result dropped");
	a_scan_follows_rel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REL && last |=> state_q == ST_SCAN && idx_q == '0)
		else $error("bad rel to scan");
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && last |=> time_q == $past(time_q) + 32'd1)
		else $error("time step");
	a_idle_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_busy_q |-> out_id_q == '0) else $error("idle id");
`endif

endmodule
